// ===== rtl/core/glfi_pkg.sv =====
package glfi_pkg;

  localparam int MAX_PHASES   = 32;
  localparam int SAMPLE_BITS  = 24;
  localparam int PHASE_BITS   = 6;
  localparam int DIST_BITS    = PHASE_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(SAMPLE_BITS);
  localparam int QDEPTH       = 2;
  localparam int QAW          = $clog2(QDEPTH);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [DIST_BITS-1:0]          dist_t;

  typedef struct packed {
    sample_t sample_real;
    sample_t sample_imag;
    logic    trace_last;
  } in_word_t;

  typedef struct packed {
    sample_t out_real;
    sample_t out_imag;
    phase_t  out_phase;
    logic    run_last;
    logic    trace_done;
  } out_word_t;

  // one queued command: pend words from base (copied or ramped toward fin), then fin
  typedef struct packed {
    sample_t base_real;
    sample_t base_imag;
    sample_t fin_real;
    sample_t fin_imag;
    phase_t  pend;
    phase_t  first;
    logic    interp;
    logic    ending;
  } cmd_t;

endpackage

// ===== rtl/core/glfi_front.sv =====
module glfi_front import glfi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  sample_t held_real_r, held_real_nxt;
  sample_t held_imag_r, held_imag_nxt;
  logic    have_filled_r, have_filled_nxt;
  phase_t  phase_count_r, phase_count_nxt;
  phase_t  pending_gap_r, pending_gap_nxt;

  logic    accept;
  logic    ending;
  logic    filled;
  phase_t  pend;
  phase_t  first;
  sample_t base_real;
  sample_t base_imag;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    filled = (in_data.sample_real != '0) || (in_data.sample_imag != '0);
    ending = in_data.trace_last ||
             (({1'b0, phase_count_r} + DIST_BITS'(1)) >= DIST_BITS'(MAX_PHASES));
    if (pending_gap_r > phase_count_r) begin
      pend  = phase_count_r;
      first = '0;
    end else begin
      pend  = pending_gap_r;
      first = phase_count_r - pending_gap_r;
    end

    if (have_filled_r) begin
      base_real = held_real_r;
      base_imag = held_imag_r;
    end else if (filled) begin
      base_real = in_data.sample_real;
      base_imag = in_data.sample_imag;
    end else begin
      base_real = '0;
      base_imag = '0;
    end

    q_push          = accept && (filled || ending);
    q_cmd.base_real = base_real;
    q_cmd.base_imag = base_imag;
    q_cmd.fin_real  = filled ? in_data.sample_real : base_real;
    q_cmd.fin_imag  = filled ? in_data.sample_imag : base_imag;
    q_cmd.pend      = pend;
    q_cmd.first     = first;
    q_cmd.interp    = filled && have_filled_r;
    q_cmd.ending    = ending;

    held_real_nxt   = held_real_r;
    held_imag_nxt   = held_imag_r;
    have_filled_nxt = have_filled_r;
    phase_count_nxt = phase_count_r;
    pending_gap_nxt = pending_gap_r;
    if (accept) begin
      if (ending) begin
        held_real_nxt   = '0;
        held_imag_nxt   = '0;
        have_filled_nxt = 1'b0;
        phase_count_nxt = '0;
        pending_gap_nxt = '0;
      end else begin
        phase_count_nxt = phase_count_r + PHASE_BITS'(1);
        if (filled) begin
          held_real_nxt   = in_data.sample_real;
          held_imag_nxt   = in_data.sample_imag;
          have_filled_nxt = 1'b1;
          pending_gap_nxt = '0;
        end else begin
          pending_gap_nxt = pend + PHASE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_real_r   <= '0;
      held_imag_r   <= '0;
      have_filled_r <= 1'b0;
      phase_count_r <= '0;
      pending_gap_r <= '0;
    end else begin
      held_real_r   <= held_real_nxt;
      held_imag_r   <= held_imag_nxt;
      have_filled_r <= have_filled_nxt;
      phase_count_r <= phase_count_nxt;
      pending_gap_r <= pending_gap_nxt;
    end
  end

endmodule

// ===== rtl/core/glfi_fifo.sv =====
module glfi_fifo import glfi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/glfi_div.sv =====
module glfi_div import glfi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] dividend,
  input  dist_t                  divisor,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] quot,
  output dist_t                  rem
);

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [SAMPLE_BITS-1:0]  quot_r;
  dist_t                   rem_r;
  dist_t                   dvs_r;

  logic [DIST_BITS:0]      trial;
  logic [DIST_BITS:0]      trial_sub;
  logic                    qbit;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial     = {rem_r, quot_r[SAMPLE_BITS-1]};
    trial_sub = trial - {1'b0, dvs_r};
    qbit      = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(SAMPLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[SAMPLE_BITS-2:0], qbit};
      rem_r  <= qbit ? trial_sub[DIST_BITS-1:0] : trial[DIST_BITS-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/glfi_back.sv =====
module glfi_back import glfi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t    state_r, state_nxt;
  cmd_t      cmd_r, cmd_nxt;
  phase_t    j_r, j_nxt;
  logic      neg_re_r, neg_re_nxt;
  logic      neg_im_r, neg_im_nxt;
  logic [SAMPLE_BITS-1:0] q_re_r, q_re_nxt;
  logic [SAMPLE_BITS-1:0] q_im_r, q_im_nxt;
  dist_t     r_re_r, r_re_nxt;
  dist_t     r_im_r, r_im_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;

  logic [SAMPLE_BITS:0]   diff_re;
  logic [SAMPLE_BITS:0]   diff_im;
  logic [SAMPLE_BITS:0]   abs_re;
  logic [SAMPLE_BITS:0]   abs_im;
  logic                   div_start;
  dist_t                  head_dist;
  dist_t                  span;
  logic                   div_done_re;
  logic                   div_done_im;
  logic [SAMPLE_BITS-1:0] qd_re;
  logic [SAMPLE_BITS-1:0] qd_im;
  dist_t                  rd_re;
  dist_t                  rd_im;
  logic [DIST_BITS:0]     rsum_re;
  logic [DIST_BITS:0]     rsum_im;
  logic                   wrap_re;
  logic                   wrap_im;
  logic [SAMPLE_BITS:0]   step_re;
  logic [SAMPLE_BITS:0]   step_im;
  logic [SAMPLE_BITS:0]   val_re;
  logic [SAMPLE_BITS:0]   val_im;
  logic                   slot_free;

  always_comb begin
    diff_re   = {head.fin_real[SAMPLE_BITS-1], head.fin_real} -
                {head.base_real[SAMPLE_BITS-1], head.base_real};
    diff_im   = {head.fin_imag[SAMPLE_BITS-1], head.fin_imag} -
                {head.base_imag[SAMPLE_BITS-1], head.base_imag};
    abs_re    = diff_re[SAMPLE_BITS] ? -diff_re : diff_re;
    abs_im    = diff_im[SAMPLE_BITS] ? -diff_im : diff_im;
    head_dist = {1'b0, head.pend} + DIST_BITS'(1);
    span      = {1'b0, cmd_r.pend} + DIST_BITS'(1);
    div_start = (state_r == S_IDLE) && !q_empty && head.interp && (head.pend != '0);
  end

  glfi_div u_div_re (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (abs_re[SAMPLE_BITS-1:0]),
    .divisor  (head_dist),
    .done     (div_done_re),
    .quot     (qd_re),
    .rem      (rd_re)
  );

  glfi_div u_div_im (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (abs_im[SAMPLE_BITS-1:0]),
    .divisor  (head_dist),
    .done     (div_done_im),
    .quot     (qd_im),
    .rem      (rd_im)
  );

  // k*|diff|/span tracked as quotient and remainder, stepped by |diff|/span
  always_comb begin
    rsum_re = {1'b0, r_re_r} + {1'b0, rd_re};
    rsum_im = {1'b0, r_im_r} + {1'b0, rd_im};
    wrap_re = (rsum_re >= {1'b0, span});
    wrap_im = (rsum_im >= {1'b0, span});
    step_re = neg_re_r ? -{1'b0, q_re_r} : {1'b0, q_re_r};
    step_im = neg_im_r ? -{1'b0, q_im_r} : {1'b0, q_im_r};
    val_re  = {cmd_r.base_real[SAMPLE_BITS-1], cmd_r.base_real} + step_re;
    val_im  = {cmd_r.base_imag[SAMPLE_BITS-1], cmd_r.base_imag} + step_im;
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    j_nxt         = j_r;
    neg_re_nxt    = neg_re_r;
    neg_im_nxt    = neg_im_r;
    q_re_nxt      = q_re_r;
    q_im_nxt      = q_im_r;
    r_re_nxt      = r_re_r;
    r_im_nxt      = r_im_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    q_pop         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cmd_nxt    = head;
          j_nxt      = '0;
          neg_re_nxt = diff_re[SAMPLE_BITS];
          neg_im_nxt = diff_im[SAMPLE_BITS];
          state_nxt  = div_start ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (div_done_re && div_done_im) begin
          q_re_nxt  = qd_re;
          q_im_nxt  = qd_im;
          r_re_nxt  = rd_re;
          r_im_nxt  = rd_im;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.out_phase = cmd_r.first + j_r;
          if (j_r != cmd_r.pend) begin
            out_nxt.run_last   = 1'b0;
            out_nxt.trace_done = 1'b0;
            if (cmd_r.interp) begin
              out_nxt.out_real = val_re[SAMPLE_BITS-1:0];
              out_nxt.out_imag = val_im[SAMPLE_BITS-1:0];
            end else begin
              out_nxt.out_real = cmd_r.base_real;
              out_nxt.out_imag = cmd_r.base_imag;
            end
            j_nxt    = j_r + PHASE_BITS'(1);
            r_re_nxt = wrap_re ? DIST_BITS'(rsum_re - {1'b0, span}) : rsum_re[DIST_BITS-1:0];
            r_im_nxt = wrap_im ? DIST_BITS'(rsum_im - {1'b0, span}) : rsum_im[DIST_BITS-1:0];
            q_re_nxt = q_re_r + qd_re + SAMPLE_BITS'(wrap_re);
            q_im_nxt = q_im_r + qd_im + SAMPLE_BITS'(wrap_im);
          end else begin
            out_nxt.out_real   = cmd_r.fin_real;
            out_nxt.out_imag   = cmd_r.fin_imag;
            out_nxt.run_last   = 1'b1;
            out_nxt.trace_done = cmd_r.ending;
            state_nxt          = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    j_r      <= j_nxt;
    neg_re_r <= neg_re_nxt;
    neg_im_r <= neg_im_nxt;
    q_re_r   <= q_re_nxt;
    q_im_r   <= q_im_nxt;
    r_re_r   <= r_re_nxt;
    r_im_r   <= r_im_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/gap_fill_linear_interpolator.sv =====
// channel   dir   payload      handshake
// in_       in    in_word_t    in_valid / in_ready
// out_      out   out_word_t   out_valid / out_ready
//
// the front takes one word per cycle while its two-entry command queue has room
// a word that only extends a gap produces nothing
// the back picks up a command when idle and emits all of its results before it takes the next
// a run with interpolated phases first waits on the radix-2 divider
// reset is synchronous on rst_n and empties the queue; a stalled out_ready holds the
// output word, and the queue keeps the front accepting for two more commands
module gap_fill_linear_interpolator import glfi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_cmd;
  cmd_t q_head;

  glfi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  glfi_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  glfi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/glfi_checker.sv =====
module glfi_checker import glfi_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // the end of a trace is always the last word of its run
  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.trace_done |-> out_data.run_last)
    else $error("trace_done without run_last");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_phase < PHASE_BITS'(MAX_PHASES - 1)) ||
                  (out_data.out_phase == PHASE_BITS'(MAX_PHASES - 1)))
    else $error("phase beyond trace length");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gap_fill_linear_interpolator glfi_checker u_glfi_checker (.*);

// ===== test/glfi_trace_checker.sv =====
module glfi_trace_checker import glfi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        mismatch_count,
  output int        owed_words
);

  sample_t   held_real   = '0;
  sample_t   held_imag   = '0;
  logic      have_filled = 1'b0;
  phase_t    phase_count = '0;
  phase_t    pending_gap = '0;
  out_word_t due_words[$];
  out_word_t oldest;
  int        errs = 0;

  initial begin
    mismatch_count = 0;
    owed_words     = 0;
  end

  function automatic out_word_t make_word(longint re, longint im, phase_t ph);
    out_word_t w;
    w           = '0;
    w.out_real  = sample_t'(re);
    w.out_imag  = sample_t'(im);
    w.out_phase = ph;
    return w;
  endfunction

  function automatic void clear_trace();
    held_real   = '0;
    held_imag   = '0;
    have_filled = 1'b0;
    phase_count = '0;
    pending_gap = '0;
  endfunction

  // works out every word that one accepted sample releases
  function automatic void fill_trace_step(in_word_t w);
    longint    re, im, hr, hi, dr, di, span;
    phase_t    p, pend, first;
    logic      ending, filled;
    out_word_t run_buf [0:63];
    int        n, j;
    re     = w.sample_real;
    im     = w.sample_imag;
    p      = phase_count;
    pend   = pending_gap;
    ending = w.trace_last || (int'(p) + 1 >= MAX_PHASES);
    filled = (re != 0) || (im != 0);
    first  = p - pend;
    n      = 0;
    if (pend > p) begin
      pend  = p;
      first = '0;
    end
    if (filled) begin
      if (!have_filled) begin
        for (j = 0; j < int'(pend); j++) begin
          run_buf[n] = make_word(re, im, phase_t'(first + j));
          n++;
        end
      end else begin
        hr   = held_real;
        hi   = held_imag;
        span = longint'(pend) + 1;
        dr   = re - hr;
        di   = im - hi;
        // ramp toward the new sample, quotient truncated toward zero
        for (j = 1; j <= int'(pend); j++) begin
          run_buf[n] = make_word(hr + (dr * j) / span, hi + (di * j) / span,
                                 phase_t'(first + j - 1));
          n++;
        end
      end
      run_buf[n] = make_word(re, im, p);
      n++;
      held_real   = sample_t'(re);
      held_imag   = sample_t'(im);
      have_filled = 1'b1;
      pend        = '0;
    end else if (ending) begin
      hr = have_filled ? longint'(held_real) : 0;
      hi = have_filled ? longint'(held_imag) : 0;
      for (j = 0; j <= int'(pend); j++) begin
        run_buf[n] = make_word(hr, hi, phase_t'(first + j));
        n++;
      end
      pend = '0;
    end else begin
      pend = pend + 1'b1;
    end
    if (n > 0) begin
      run_buf[n-1].run_last   = 1'b1;
      run_buf[n-1].trace_done = ending;
    end
    for (j = 0; j < n; j++) due_words.push_back(run_buf[j]);
    if (ending) begin
      clear_trace();
    end else begin
      phase_count = p + 1'b1;
      pending_gap = pend;
    end
  endfunction

  function automatic void check_field(string fname, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_trace();
      due_words.delete();
    end else begin
      if (in_valid && in_ready) fill_trace_step(in_data);
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          errs++;
        end else begin
          oldest = due_words.pop_front();
          check_field("out_real", oldest.out_real, out_data.out_real);
          check_field("out_imag", oldest.out_imag, out_data.out_imag);
          check_field("out_phase", oldest.out_phase, out_data.out_phase);
          check_field("run_last", oldest.run_last, out_data.run_last);
          check_field("trace_done", oldest.trace_done, out_data.trace_done);
        end
      end
    end
    mismatch_count <= errs;
    owed_words     <= due_words.size();
  end

endmodule

// ===== test/gap_fill_linear_interpolator_tb.sv =====
module gap_fill_linear_interpolator_tb;
  import glfi_pkg::*;

  localparam int      TIMEOUT_CYCLES = 1000000;
  localparam int      RANDOM_WORDS   = 430;
  localparam sample_t SMAX           = 24'sh7FFFFF;
  localparam sample_t SMIN           = 24'sh800000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_word_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic [8:0] stall_cyc = '0;
  int         mismatch_count;
  int         owed_words;
  int         words_sent = 0;
  int         burst_left = 4;

  always #2 clk = ~clk;

  gap_fill_linear_interpolator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  glfi_trace_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .owed_words     (owed_words)
  );

  // receiver cycles through always ready, mostly ready, mostly stalled, long periodic stalls
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    case (stall_cyc[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_cyc[4:0] < 5'd19);
    endcase
  end

  task automatic send_word(sample_t re, sample_t im, logic last);
    in_data  <= '{sample_real: re, sample_imag: im, trace_last: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
    end
  endtask

  function automatic sample_t pick_value();
    case ($urandom_range(0, 3))
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 16)) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: return SMAX;
          1: return SMIN;
          2: return -1;
          default: return 1;
        endcase
      end
      default: return sample_t'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic send_rand(int empty_pct, logic last);
    if ($urandom_range(0, 99) < empty_pct) send_word('0, '0, last);
    else send_word(pick_value(), pick_value(), last);
  endtask

  task automatic run_trace(int len, int empty_pct);
    int i;
    for (i = 0; i < len; i++) send_rand(empty_pct, i == len - 1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all filled, full-scale values then unit values
    send_word(SMAX, SMIN, 1'b0);
    send_word(SMIN, SMAX, 1'b0);
    send_word(1, 0, 1'b0);
    send_word(0, -1, 1'b1);
    // leading empties, interpolated gap across full scale, trailing empties
    send_word(0, 0, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(5, -7, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(SMIN, SMAX, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(SMAX, SMIN, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(0, 0, 1'b1);
    // trace with nothing filled
    send_word(0, 0, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(0, 0, 1'b1);
    // one-word traces, empty and filled
    send_word(0, 0, 1'b1);
    send_word(-3, 0, 1'b1);
    // truncation toward zero on negative steps
    send_word(7, -7, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(0, 0, 1'b0);
    send_word(-4, 4, 1'b1);

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: run_trace($urandom_range(1, 10), 40);
        5: run_trace($urandom_range(20, 40), 50);
        6: begin
          // widest gap, closed by the word the block forces to end the trace
          repeat (MAX_PHASES - 1) send_word('0, '0, 1'b0);
          send_rand(0, $urandom_range(0, 1));
        end
        7: repeat ($urandom_range(1, 8)) send_rand(40, $urandom_range(0, 3) == 0);
        8: run_trace($urandom_range(5, 32), 85);
        default: run_trace($urandom_range(1, 6), 100);
      endcase
    end
    in_valid <= 1'b0;

    // let the owed count take in the words of the last accepted sample
    @(posedge clk);
    while (owed_words != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && owed_words == 0) begin
      $display("gap_fill_linear_interpolator regression: pass");
    end else begin
      $display("gap_fill_linear_interpolator regression: fail");
    end
    $finish;
  end

  initial begin
    #(4 * TIMEOUT_CYCLES);
    $display("gap_fill_linear_interpolator regression: fail");
    $finish;
  end

endmodule
